// ===== src/ttx_pkg.sv =====
// Teletext line decoder package: shared constants, event and result types,
// and the Hamming 8/4 nibble table. No dependencies.
package ttx_pkg;

	// Transport packet and data unit geometry
	localparam logic [7:0] PKT_LEN   = 8'd188;
	localparam logic [7:0] TS_HDR    = 8'd4;
	localparam logic [5:0] UNIT_LEN  = 6'd46;
	localparam logic [5:0] UNIT_HDR  = 6'd4;
	localparam logic [5:0] LINE_LEN  = 6'd42;

	// Data unit ids that carry teletext
	localparam logic [7:0] UNIT_ID_NONSUB = 8'h02;
	localparam logic [7:0] UNIT_ID_SUB    = 8'h03;

	// Line byte indexes with a fixed meaning
	localparam logic [5:0] IDX_ADDR_LO  = 6'd0;
	localparam logic [5:0] IDX_ADDR_HI  = 6'd1;
	localparam logic [5:0] IDX_PAGE_LO  = 6'd2;
	localparam logic [5:0] IDX_PAGE_HI  = 6'd3;
	localparam logic [5:0] IDX_ERASE    = 6'd5;
	localparam logic [5:0] IDX_CONTROL  = 6'd9;
	localparam logic [5:0] COL_OFFSET   = 6'd2;

	localparam logic [4:0] ROW_HEADER   = 5'd0;
	localparam logic [4:0] ROW_LAST     = 5'd23;
	localparam logic [3:0] DIGIT_NONE   = 4'hf;
	localparam logic [9:0] PAGE_NONE    = 10'd0;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_CLOSE  = 2'd2
	} kind_t;

	// One line byte handed from front to back
	typedef struct packed {
		logic [5:0] idx;
		logic [7:0] code;
	} ttx_evt_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [2:0] magazine;
		logic [4:0] row;
		logic [5:0] column;
		logic [6:0] character;
		logic [9:0] page_number;
		logic       erase_page;
		logic [2:0] language;
	} ttx_res_t;

	// Low nibble of the Hamming 8/4 decode, error marks ignored
	localparam logic [3:0] HAM84_NIB [256] = '{
		4'h1,4'hf,4'h1,4'h1,4'hf,4'h0,4'h1,4'hf,4'hf,4'h2,4'h1,4'hf,4'ha,4'hf,4'hf,4'h7,
		4'hf,4'h0,4'h1,4'hf,4'h0,4'h0,4'hf,4'h0,4'h6,4'hf,4'hf,4'hb,4'hf,4'h0,4'h3,4'hf,
		4'hf,4'hc,4'h1,4'hf,4'h4,4'hf,4'hf,4'h7,4'h6,4'hf,4'hf,4'h7,4'hf,4'h7,4'h7,4'h7,
		4'h6,4'hf,4'hf,4'h5,4'hf,4'h0,4'hd,4'hf,4'h6,4'h6,4'h6,4'hf,4'h6,4'hf,4'hf,4'h7,
		4'hf,4'h2,4'h1,4'hf,4'h4,4'hf,4'hf,4'h9,4'h2,4'h2,4'hf,4'h2,4'hf,4'h2,4'h3,4'hf,
		4'h8,4'hf,4'hf,4'h5,4'hf,4'h0,4'h3,4'hf,4'hf,4'h2,4'h3,4'hf,4'h3,4'hf,4'h3,4'h3,
		4'h4,4'hf,4'hf,4'h5,4'h4,4'h4,4'h4,4'hf,4'hf,4'h2,4'hf,4'hf,4'h4,4'hf,4'hf,4'h7,
		4'hf,4'h5,4'h5,4'h5,4'h4,4'hf,4'hf,4'h5,4'h6,4'hf,4'hf,4'h5,4'hf,4'he,4'h3,4'hf,
		4'hf,4'hc,4'h1,4'hf,4'ha,4'hf,4'hf,4'h9,4'ha,4'hf,4'hf,4'hb,4'ha,4'ha,4'ha,4'hf,
		4'h8,4'hf,4'hf,4'hb,4'hf,4'h0,4'hd,4'hf,4'hf,4'hb,4'hb,4'hb,4'ha,4'hf,4'hf,4'hb,
		4'hc,4'hc,4'hf,4'hc,4'hf,4'hc,4'hd,4'hf,4'hf,4'hc,4'hf,4'hf,4'ha,4'hf,4'hf,4'h7,
		4'hf,4'hc,4'hd,4'hf,4'hd,4'hf,4'hd,4'hd,4'h6,4'hf,4'hf,4'hb,4'hf,4'he,4'hd,4'hf,
		4'h8,4'hf,4'hf,4'h9,4'hf,4'h9,4'h9,4'h9,4'hf,4'h2,4'hf,4'hf,4'ha,4'hf,4'hf,4'h9,
		4'h8,4'h8,4'h8,4'hf,4'h8,4'hf,4'hf,4'h9,4'h8,4'hf,4'hf,4'hb,4'hf,4'he,4'h3,4'hf,
		4'hf,4'hc,4'hf,4'hf,4'h4,4'hf,4'hf,4'h9,4'hf,4'hf,4'hf,4'hf,4'hf,4'he,4'hf,4'hf,
		4'h8,4'hf,4'hf,4'h5,4'hf,4'he,4'hd,4'hf,4'hf,4'he,4'hf,4'hf,4'he,4'he,4'hf,4'he
	};

endpackage

// ===== src/ttx_front.sv =====
// Front end: tracks the byte position in a transport packet and the offset in
// its data units, and forwards bit-reversed line bytes of teletext units.
// Depends on ttx_pkg.
module ttx_front import ttx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] data_byte,
	input  logic       packet_start,
	input  logic       q_full,
	output logic       in_ready,
	output logic       push,
	output ttx_evt_t   push_evt
);

	logic [7:0] pos_q;
	logic [5:0] off_q;
	logic       unit_ok_q;
	logic [7:0] pos_eff;
	logic       accept;
	logic       active;
	logic       in_unit;
	logic [7:0] code_rev;

	// Take a beat whenever the queue has room
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pos_eff  = packet_start ? 8'd0 : pos_q;
	assign active   = pos_eff < PKT_LEN;
	assign in_unit  = pos_eff >= TS_HDR;

	// Teletext bits arrive least significant first: reverse the byte
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			code_rev[i] = data_byte[7 - i];
		end
	end

	// Forward line bytes of accepted units only
	assign push          = accept && active && in_unit && unit_ok_q && (off_q >= UNIT_HDR);
	assign push_evt.idx  = off_q - UNIT_HDR;
	assign push_evt.code = code_rev;

	// Advance position, unit offset and unit id check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= PKT_LEN;
			off_q     <= '0;
			unit_ok_q <= 1'b0;
		end else if (accept && active) begin
			pos_q <= pos_eff + 8'd1;
			if (pos_eff == TS_HDR - 8'd1) begin
				off_q <= '0;
			end else if (in_unit) begin
				off_q <= (off_q == UNIT_LEN - 6'd1) ? 6'd0 : off_q + 6'd1;
				if (off_q == 6'd0) begin
					unit_ok_q <= (data_byte == UNIT_ID_NONSUB) || (data_byte == UNIT_ID_SUB);
				end
			end
		end
	end

endmodule

// ===== src/ttx_queue.sv =====
// Short queue of line bytes between front and back end.
// Depends on ttx_pkg.
module ttx_queue import ttx_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ttx_evt_t push_evt,
	input  logic     pop,
	output ttx_evt_t head_evt,
	output logic     full,
	output logic     empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ttx_evt_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign head_evt = mem_q[rd_q];

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_evt;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== src/ttx_back.sv =====
// Back end: decodes line address, page header and character bytes, keeps the
// open page of each magazine and drives the registered result.
// Depends on ttx_pkg.
module ttx_back import ttx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  ttx_evt_t head_evt,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output ttx_res_t res
);

	logic [3:0] pend_q;
	logic [2:0] mag_q;
	logic [4:0] row_q;
	logic       hdr_valid_q;
	logic       hdr_erase_q;
	logic [9:0] page_q [8];
	logic       out_valid_q;
	ttx_res_t   res_q;

	logic [3:0] nib;
	logic [2:0] mag_new;
	logic [4:0] row_new;
	logic [2:0] page_addr;
	logic [9:0] page_rd;
	logic [3:0] mag_hundreds;
	logic [9:0] page_new;
	logic       is_addr;

	logic       emit;
	ttx_res_t   emit_res;
	logic [3:0] pend_d;
	logic [2:0] mag_d;
	logic [4:0] row_d;
	logic       hdr_valid_d;
	logic       hdr_erase_d;
	logic       page_we;
	logic [9:0] page_wd;

	// Take the next line byte when the result register is free or draining
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign nib       = HAM84_NIB[head_evt.code];
	assign mag_new   = pend_q[2:0];
	assign row_new   = {nib, pend_q[3]};
	assign is_addr   = head_evt.idx == IDX_ADDR_HI;
	assign page_addr = is_addr ? mag_new : mag_q;
	assign page_rd   = page_q[page_addr];

	// Page number: magazine (0 reads as 8) hundreds, then tens and units digits
	assign mag_hundreds = (mag_q == 3'd0) ? 4'd8 : {1'b0, mag_q};
	assign page_new     = 10'(mag_hundreds * 10'd100) + 10'(nib * 10'd10) + 10'(pend_q);

	// Decode one line byte
	always_comb begin
		emit        = 1'b0;
		emit_res    = '0;
		pend_d      = pend_q;
		mag_d       = mag_q;
		row_d       = row_q;
		hdr_valid_d = hdr_valid_q;
		hdr_erase_d = hdr_erase_q;
		page_we     = 1'b0;
		page_wd     = PAGE_NONE;
		emit_res.magazine = mag_q;
		if (head_evt.idx == IDX_ADDR_LO) begin
			pend_d = nib;
		end else if (is_addr) begin
			mag_d             = mag_new;
			row_d             = row_new;
			hdr_valid_d       = 1'b0;
			emit_res.magazine = mag_new;
			// Close the magazine's open page on a new header row
			if (row_new == ROW_HEADER && page_rd != PAGE_NONE) begin
				emit                 = 1'b1;
				emit_res.kind        = KIND_CLOSE;
				emit_res.page_number = page_rd;
				page_we              = 1'b1;
			end
		end else if (row_q == ROW_HEADER) begin
			priority if (head_evt.idx == IDX_PAGE_LO) begin
				pend_d = nib;
			end else if (head_evt.idx == IDX_PAGE_HI) begin
				if (nib == DIGIT_NONE && pend_q == DIGIT_NONE) begin
					hdr_valid_d = 1'b0;
				end else begin
					page_we     = 1'b1;
					page_wd     = page_new;
					hdr_valid_d = 1'b1;
					hdr_erase_d = 1'b0;
				end
			end else if (head_evt.idx == IDX_ERASE) begin
				hdr_erase_d = nib[3];
			end else if (head_evt.idx == IDX_CONTROL && hdr_valid_q) begin
				emit                 = 1'b1;
				emit_res.kind        = KIND_HEADER;
				emit_res.page_number = page_rd;
				emit_res.erase_page  = hdr_erase_q;
				emit_res.language    = nib[3:1];
				hdr_valid_d          = 1'b0;
			end else begin
				hdr_valid_d = hdr_valid_q;
			end
		end else if (row_q <= ROW_LAST) begin
			emit               = 1'b1;
			emit_res.kind      = KIND_CHAR;
			emit_res.row       = row_q;
			emit_res.column    = head_evt.idx - COL_OFFSET;
			emit_res.character = head_evt.code[6:0];
		end
	end

	// Hold line state and open pages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			mag_q       <= '0;
			row_q       <= '0;
			hdr_valid_q <= 1'b0;
			hdr_erase_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				page_q[i] <= PAGE_NONE;
			end
		end else begin
			if (pop) begin
				pend_q      <= pend_d;
				mag_q       <= mag_d;
				row_q       <= row_d;
				hdr_valid_q <= hdr_valid_d;
				hdr_erase_q <= hdr_erase_d;
				if (page_we) begin
					page_q[page_addr] <= page_wd;
				end
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= emit_res;
		end
	end

	a_char_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind == KIND_CHAR) |->
		(res_q.row != 5'd0 && res_q.row <= ROW_LAST && res_q.column < 6'd40))
		else $error("character write outside page");
	a_page_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind != KIND_CHAR) |-> (res_q.page_number >= 10'd100))
		else $error("header or close without a valid page");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(res_q)))
		else $error("result changed while stalled");

endmodule

// ===== src/teletext_packet_line_decoder.sv =====
// Teletext packet line decoder
// Input channel (in_valid/in_ready): one transport packet byte per beat, with
// packet_start high on byte 0 of each 188-byte packet. Output channel
// (out_valid/out_ready): character writes, page headers and page closes.
// Path: an accepted byte is registered in the byte queue, and a result it
// causes is registered in the result register that drives out_valid.
// Throughput: one byte per cycle while no receiver stall fills the queue;
// front end, byte queue and back end each handle one byte per cycle.
// Reset: no page is open in any magazine and the decoder ignores bytes until
// a packet_start beat arrives.
// Receiver stall: the result register holds, the back end stops, the byte
// queue (QUEUE_DEPTH entries) fills, and in_ready drops once it is full.
// Depends on ttx_pkg, ttx_front, ttx_queue and ttx_back.
module teletext_packet_line_decoder import ttx_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       packet_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [2:0] magazine,
	output logic [4:0] row,
	output logic [5:0] column,
	output logic [6:0] character,
	output logic [9:0] page_number,
	output logic       erase_page,
	output logic [2:0] language
);

	logic     push;
	ttx_evt_t push_evt;
	logic     q_full;
	logic     q_empty;
	logic     pop;
	ttx_evt_t head_evt;
	ttx_res_t res;

	// Classify bytes
	ttx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.data_byte    (data_byte),
		.packet_start (packet_start),
		.q_full       (q_full),
		.in_ready     (in_ready),
		.push         (push),
		.push_evt     (push_evt)
	);

	// Buffer line bytes
	ttx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.pop      (pop),
		.head_evt (head_evt),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Decode lines
	ttx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_evt   (head_evt),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign kind        = res.kind;
	assign magazine    = res.magazine;
	assign row         = res.row;
	assign column      = res.column;
	assign character   = res.character;
	assign page_number = res.page_number;
	assign erase_page  = res.erase_page;
	assign language    = res.language;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for teletext_packet_line_decoder: streams transport packets
// byte by byte and checks every line event against an in-bench decoder.
// Depends on ttx_pkg (ports, kind codes, geometry) and the decoder RTL.
module tb_top;
	import ttx_pkg::*;

	localparam int RANDOM_BYTES = 300;
	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 16;
	localparam int PRINT_CAP    = 30;

	// Hamming 8/4 decode table, error marks in bit 7
	localparam logic [7:0] HAM84_LUT [256] = '{
		8'h01,8'hff,8'h81,8'h01,8'hff,8'h00,8'h01,8'hff,8'hff,8'h02,8'h01,8'hff,8'h0a,8'hff,8'hff,8'h07,
		8'hff,8'h00,8'h01,8'hff,8'h00,8'h80,8'hff,8'h00,8'h06,8'hff,8'hff,8'h0b,8'hff,8'h00,8'h03,8'hff,
		8'hff,8'h0c,8'h01,8'hff,8'h04,8'hff,8'hff,8'h07,8'h06,8'hff,8'hff,8'h07,8'hff,8'h07,8'h07,8'h87,
		8'h06,8'hff,8'hff,8'h05,8'hff,8'h00,8'h0d,8'hff,8'h86,8'h06,8'h06,8'hff,8'h06,8'hff,8'hff,8'h07,
		8'hff,8'h02,8'h01,8'hff,8'h04,8'hff,8'hff,8'h09,8'h02,8'h82,8'hff,8'h02,8'hff,8'h02,8'h03,8'hff,
		8'h08,8'hff,8'hff,8'h05,8'hff,8'h00,8'h03,8'hff,8'hff,8'h02,8'h03,8'hff,8'h03,8'hff,8'h83,8'h03,
		8'h04,8'hff,8'hff,8'h05,8'h84,8'h04,8'h04,8'hff,8'hff,8'h02,8'h0f,8'hff,8'h04,8'hff,8'hff,8'h07,
		8'hff,8'h05,8'h05,8'h85,8'h04,8'hff,8'hff,8'h05,8'h06,8'hff,8'hff,8'h05,8'hff,8'h0e,8'h03,8'hff,
		8'hff,8'h0c,8'h01,8'hff,8'h0a,8'hff,8'hff,8'h09,8'h0a,8'hff,8'hff,8'h0b,8'h8a,8'h0a,8'h0a,8'hff,
		8'h08,8'hff,8'hff,8'h0b,8'hff,8'h00,8'h0d,8'hff,8'hff,8'h0b,8'h0b,8'h8b,8'h0a,8'hff,8'hff,8'h0b,
		8'h0c,8'h8c,8'hff,8'h0c,8'hff,8'h0c,8'h0d,8'hff,8'hff,8'h0c,8'h0f,8'hff,8'h0a,8'hff,8'hff,8'h07,
		8'hff,8'h0c,8'h0d,8'hff,8'h0d,8'hff,8'h8d,8'h0d,8'h06,8'hff,8'hff,8'h0b,8'hff,8'h0e,8'h0d,8'hff,
		8'h08,8'hff,8'hff,8'h09,8'hff,8'h09,8'h09,8'h89,8'hff,8'h02,8'h0f,8'hff,8'h0a,8'hff,8'hff,8'h09,
		8'h88,8'h08,8'h08,8'hff,8'h08,8'hff,8'hff,8'h09,8'h08,8'hff,8'hff,8'h0b,8'hff,8'h0e,8'h03,8'hff,
		8'hff,8'h0c,8'h0f,8'hff,8'h04,8'hff,8'hff,8'h09,8'h0f,8'hff,8'h8f,8'h0f,8'hff,8'h0e,8'h0f,8'hff,
		8'h08,8'hff,8'hff,8'h05,8'hff,8'h0e,8'h0d,8'hff,8'hff,8'h0e,8'h0f,8'hff,8'h0e,8'h8e,8'hff,8'h0e
	};

	typedef struct {
		logic [7:0] data;
		logic       first;
		bit         hold;
	} ts_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       packet_start = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [2:0] magazine;
	logic [4:0] row;
	logic [5:0] column;
	logic [6:0] character;
	logic [9:0] page_number;
	logic       erase_page;
	logic [2:0] language;

	// Beats waiting to be sent and line events the decoder still owes
	ts_beat_t beat_q[$];
	ttx_res_t line_events_q[$];

	// In-bench decoder state
	int unsigned pkt_pos = PKT_LEN;
	logic        unit_live = 1'b0;
	logic [2:0]  ln_mag = '0;
	logic [4:0]  ln_row = '0;
	logic [3:0]  held_nib = '0;
	logic        hdr_armed = 1'b0;
	logic        hdr_erase = 1'b0;
	logic [9:0]  open_page [8] = '{default: PAGE_NONE};

	int       byte_total = 0;
	int       bytes_fed = 0;
	int       starts_fed = 0;
	int       pauses_done = 0;
	int       events_seen = 0;
	int       n_char = 0;
	int       n_header = 0;
	int       n_close = 0;
	int       mismatches = 0;
	int       idle_cycles = 0;
	int       tx_gap = 0;
	int       rx_stall = 0;
	bit       tx_calm = 1'b0;
	bit       rx_calm = 1'b0;
	ts_beat_t tx_beat;
	ttx_res_t rx_got;
	ttx_res_t rx_want;

	teletext_packet_line_decoder uut (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .packet_start,
		.out_valid, .out_ready, .kind, .magazine, .row, .column, .character,
		.page_number, .erase_page, .language
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] flip_bits(input logic [7:0] v);
		logic [7:0] f;
		for (int i = 0; i < 8; i++) f[i] = v[7 - i];
		return f;
	endfunction

	// Decode one packet byte; returns 1 when it yields a line event
	function automatic bit decode_byte(input logic [7:0] raw, input logic first,
		output ttx_res_t ev);
		int unsigned slot;
		int unsigned j;
		int unsigned page;
		logic [7:0] code;
		logic [7:0] addr;
		logic [3:0] nib;
		ev = '0;
		if (first) begin
			pkt_pos = 0;
			unit_live = 1'b0;
			hdr_armed = 1'b0;
		end
		if (pkt_pos >= PKT_LEN) return 1'b0;
		slot = pkt_pos;
		pkt_pos++;
		if (slot < TS_HDR) return 1'b0;
		slot = (slot - TS_HDR) % UNIT_LEN;
		// unit id byte decides whether the unit is decoded at all
		if (slot == 0) begin
			unit_live = (raw == UNIT_ID_NONSUB) || (raw == UNIT_ID_SUB);
			hdr_armed = 1'b0;
			return 1'b0;
		end
		if (!unit_live || slot < UNIT_HDR) return 1'b0;
		j = slot - UNIT_HDR;
		code = flip_bits(raw);
		nib = HAM84_LUT[code][3:0];
		if (j == IDX_ADDR_LO) begin
			held_nib = nib;
			return 1'b0;
		end
		// full address known: a header row closes the magazine's open page
		if (j == IDX_ADDR_HI) begin
			addr = {nib, held_nib};
			ln_mag = addr[2:0];
			ln_row = addr[7:3];
			hdr_armed = 1'b0;
			if (ln_row == ROW_HEADER && open_page[ln_mag] != PAGE_NONE) begin
				ev.kind = KIND_CLOSE;
				ev.magazine = ln_mag;
				ev.page_number = open_page[ln_mag];
				open_page[ln_mag] = PAGE_NONE;
				return 1'b1;
			end
			return 1'b0;
		end
		ev.magazine = ln_mag;
		if (ln_row == ROW_HEADER) begin
			if (j == IDX_PAGE_LO) begin
				held_nib = nib;
			end else if (j == IDX_PAGE_HI) begin
				if (nib == DIGIT_NONE && held_nib == DIGIT_NONE) begin
					hdr_armed = 1'b0;
				end else begin
					page = ((ln_mag == 3'd0) ? 8 : int'(ln_mag)) * 100
						+ int'(nib) * 10 + int'(held_nib);
					open_page[ln_mag] = page[9:0];
					hdr_armed = 1'b1;
					hdr_erase = 1'b0;
				end
			end else if (j == IDX_ERASE) begin
				hdr_erase = nib[3];
			end else if (j == IDX_CONTROL && hdr_armed) begin
				ev.kind = KIND_HEADER;
				ev.page_number = open_page[ln_mag];
				ev.erase_page = hdr_erase;
				ev.language = nib[3:1];
				hdr_armed = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		end
		// display rows write one character per line byte
		if (ln_row <= ROW_LAST) begin
			ev.kind = KIND_CHAR;
			ev.row = ln_row;
			ev.column = 6'(j - COL_OFFSET);
			ev.character = code[6:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Raw byte whose reversed code decodes to the given nibble
	function automatic logic [7:0] raw_for_nib(input logic [3:0] n);
		logic [7:0] h;
		h = 8'($urandom_range(0, 255));
		while (HAM84_LUT[h][3:0] != n) h = 8'($urandom_range(0, 255));
		return flip_bits(h);
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_event(input ttx_res_t got, input ttx_res_t want);
		if (got.kind !== want.kind)
			report_mismatch($sformatf("event %0d kind: got %0d expected %0d",
				events_seen, got.kind, want.kind));
		if (got.magazine !== want.magazine)
			report_mismatch($sformatf("event %0d magazine: got %0d expected %0d",
				events_seen, got.magazine, want.magazine));
		if (got.row !== want.row)
			report_mismatch($sformatf("event %0d row: got %0d expected %0d",
				events_seen, got.row, want.row));
		if (got.column !== want.column)
			report_mismatch($sformatf("event %0d column: got %0d expected %0d",
				events_seen, got.column, want.column));
		if (got.character !== want.character)
			report_mismatch($sformatf("event %0d character: got %0h expected %0h",
				events_seen, got.character, want.character));
		if (got.page_number !== want.page_number)
			report_mismatch($sformatf("event %0d page_number: got %0d expected %0d",
				events_seen, got.page_number, want.page_number));
		if (got.erase_page !== want.erase_page)
			report_mismatch($sformatf("event %0d erase_page: got %0d expected %0d",
				events_seen, got.erase_page, want.erase_page));
		if (got.language !== want.language)
			report_mismatch($sformatf("event %0d language: got %0d expected %0d",
				events_seen, got.language, want.language));
	endtask

	task automatic push_byte(input logic [7:0] b, input logic s);
		beat_q.push_back('{data: b, first: s, hold: 1'b0});
		byte_total++;
	endtask

	// Marker: the sender waits here until every owed event has arrived
	task automatic push_pause();
		beat_q.push_back('{data: 8'h00, first: 1'b0, hold: 1'b1});
	endtask

	task automatic push_head(input int nbytes);
		for (int k = 0; k < nbytes; k++) push_byte(8'($urandom_range(0, 255)), k == 0);
	endtask

	// One data unit; noise leaves every line byte random
	task automatic push_unit(input logic [7:0] id, input logic [2:0] mag,
		input logic [4:0] rw, input logic [3:0] units, input logic [3:0] tens,
		input logic erase, input logic [2:0] lang, input bit noise, input int nbytes);
		logic [7:0] addr;
		logic [7:0] b;
		logic [2:0] pad;
		int j;
		addr = {rw, mag};
		for (int k = 0; k < nbytes; k++) begin
			b = 8'($urandom_range(0, 255));
			pad = 3'($urandom_range(0, 7));
			j = k - UNIT_HDR;
			if (k == 0) begin
				b = id;
			end else if (k >= UNIT_HDR && !noise) begin
				if (j == IDX_ADDR_LO) b = raw_for_nib(addr[3:0]);
				else if (j == IDX_ADDR_HI) b = raw_for_nib(addr[7:4]);
				else if (rw == ROW_HEADER) begin
					if (j == IDX_PAGE_LO) b = raw_for_nib(units);
					else if (j == IDX_PAGE_HI) b = raw_for_nib(tens);
					else if (j == IDX_ERASE) b = raw_for_nib({erase, pad});
					else if (j == IDX_CONTROL) b = raw_for_nib({lang, pad[0]});
				end
			end
			push_byte(b, 1'b0);
		end
	endtask

	task automatic push_random_unit(input int nbytes);
		int r;
		logic [7:0] id;
		logic [2:0] mag;
		logic [4:0] rw;
		logic [3:0] units;
		logic [3:0] tens;
		r = $urandom_range(0, 99);
		id = 8'($urandom_range(UNIT_ID_NONSUB, UNIT_ID_SUB));
		mag = 3'($urandom_range(0, 7));
		units = 4'($urandom_range(0, 15));
		tens = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0) begin
			units = DIGIT_NONE;
			tens = DIGIT_NONE;
		end
		if (r < 35) rw = ROW_HEADER;
		else if (r < 75) rw = 5'($urandom_range(1, ROW_LAST));
		else if (r < 83) rw = 5'($urandom_range(ROW_LAST + 1, 31));
		else begin
			rw = 5'($urandom_range(0, 31));
			if (r < 90) begin
				do id = 8'($urandom_range(0, 255));
				while (id == UNIT_ID_NONSUB || id == UNIT_ID_SUB);
			end
		end
		push_unit(id, mag, rw, units, tens, 1'($urandom_range(0, 1)),
			3'($urandom_range(0, 7)), r >= 90, nbytes);
	endtask

	// Sender: count and decode each beat taken, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			packet_start <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				ttx_res_t ev;
				bytes_fed++;
				if (packet_start) starts_fed++;
				if (decode_byte(data_byte, packet_start, ev)) line_events_q.push_back(ev);
			end
			if (!in_valid || in_ready) begin
				if (beat_q.size() != 0 && beat_q[0].hold && line_events_q.size() == 0) begin
					void'(beat_q.pop_front());
					pauses_done++;
				end
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (beat_q.size() == 0 || beat_q[0].hold) begin
					in_valid <= 1'b0;
				end else begin
					tx_beat = beat_q.pop_front();
					data_byte <= tx_beat.data;
					packet_start <= tx_beat.first;
					in_valid <= 1'b1;
					if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
					tx_gap = pick_gap(tx_calm);
				end
			end
		end
	end

	// Receiver: compare each event taken, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rx_got.kind = kind_t'(kind);
				rx_got.magazine = magazine;
				rx_got.row = row;
				rx_got.column = column;
				rx_got.character = character;
				rx_got.page_number = page_number;
				rx_got.erase_page = erase_page;
				rx_got.language = language;
				if (line_events_q.size() == 0) begin
					report_mismatch($sformatf("event %0d arrived with none owed, kind %0d",
						events_seen, kind));
				end else begin
					rx_want = line_events_q.pop_front();
					check_event(rx_got, rx_want);
					case (rx_want.kind)
						KIND_CHAR:   n_char++;
						KIND_HEADER: n_header++;
						default:     n_close++;
					endcase
				end
				events_seen++;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
				rx_stall = pick_gap(rx_calm);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] timeout: nothing moved for %0d cycles, %0d events owed",
					$time, idle_cycles, line_events_q.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int cut;
		int dir_bytes;

		// bytes before any packet start are dropped
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'($urandom_range(0, 255)), 1'b0);

		// header in magazine 0 opens page 800, row 1 text, header with no page
		// closes it, magazine 7 opens page 855 from tens digit E and units digit F
		push_head(TS_HDR);
		push_unit(UNIT_ID_NONSUB, 3'd0, ROW_HEADER, 4'h0, 4'h0, 1'b1, 3'd7, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_SUB, 3'd0, 5'd1, 4'h0, 4'h0, 1'b0, 3'd0, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_NONSUB, 3'd0, ROW_HEADER, DIGIT_NONE, DIGIT_NONE, 1'b0, 3'd0,
			1'b0, UNIT_LEN);
		push_unit(UNIT_ID_SUB, 3'd7, ROW_HEADER, 4'hf, 4'he, 1'b0, 3'd0, 1'b0, UNIT_LEN);

		// rejected ids carrying a header, last display row, ignored high row
		push_head(TS_HDR);
		push_unit(8'h00, 3'd7, ROW_HEADER, 4'h1, 4'h2, 1'b0, 3'd3, 1'b0, UNIT_LEN);
		push_unit(8'hff, 3'd7, ROW_HEADER, 4'h1, 4'h2, 1'b0, 3'd3, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_SUB, 3'd5, ROW_LAST, 4'h0, 4'h0, 1'b0, 3'd0, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_NONSUB, 3'd7, 5'd31, 4'h0, 4'h0, 1'b0, 3'd0, 1'b0, UNIT_LEN);

		// restart mid header: page opens but its header beat is dropped
		push_head(TS_HDR);
		push_unit(UNIT_ID_NONSUB, 3'd3, ROW_HEADER, 4'h9, 4'h9, 1'b1, 3'd2, 1'b0,
			UNIT_HDR + IDX_CONTROL);

		// close after restart, page 964, smallest page, then trailing bytes
		push_head(TS_HDR);
		push_unit(UNIT_ID_SUB, 3'd3, ROW_HEADER, 4'h0, 4'h1, 1'b0, 3'd0, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_NONSUB, 3'd0, ROW_HEADER, 4'he, 4'hf, 1'b1, 3'd5, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_SUB, 3'd1, ROW_HEADER, 4'h0, 4'h0, 1'b0, 3'd1, 1'b0, UNIT_LEN);
		push_unit(UNIT_ID_NONSUB, 3'd3, 5'd1, 4'h0, 4'h0, 1'b0, 3'd0, 1'b0, UNIT_LEN);
		repeat (5) push_byte(8'($urandom_range(0, 255)), 1'b0);
		push_pause();
		dir_bytes = byte_total;

		// random packets, some cut short, some broken inside the header
		while (byte_total < dir_bytes + RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				push_head($urandom_range(1, TS_HDR - 1));
			end else begin
				push_head(TS_HDR);
				cut = (r < 20) ? $urandom_range(0, 3) : 4;
				for (int u = 0; u < 4; u++) begin
					if (u == cut) begin
						push_random_unit($urandom_range(1, UNIT_LEN - 1));
						break;
					end
					push_random_unit(UNIT_LEN);
				end
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
			end
			if ($urandom_range(0, 5) == 0) push_pause();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain stimulus, then owed events, then let the pipeline settle
		while (beat_q.size() != 0 || in_valid) @(posedge clk);
		while (line_events_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (line_events_q.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", line_events_q.size()));

		$display("Sent %0d packet bytes over %0d packet starts with %0d full drains",
			bytes_fed, starts_fed, pauses_done);
		$display("Compared %0d character writes, %0d page headers, %0d page closes",
			n_char, n_header, n_close);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
